[rtl/assert_macros.svh]
// Assertion macros for the port-level checker of the interpolator.
// No dependencies; included by file name where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

[rtl/plin_pkg.sv]
// Shared types and constants of the piecewise linear interpolator.
// No dependencies; imported by every module of the block.
package plin_pkg;

   localparam int MAX_NODES = 64;
   localparam int IDX_W     = $clog2(MAX_NODES);
   localparam int CNT_W     = $clog2(MAX_NODES + 1);
   localparam int DATA_W    = 32;
   localparam int STEP_W    = $clog2(DATA_W);

   typedef enum logic [1:0] {
      REQ_INSERT = 2'd0,
      REQ_QUERY  = 2'd1,
      REQ_CLEAR  = 2'd2,
      REQ_UNUSED = 2'd3
   } req_kind_type;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_RANGE   = 3'd1,
      ST_INVALID = 3'd2,
      ST_EMPTY   = 3'd3,
      ST_FULL    = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      VAL_ZERO   = 2'd0,
      VAL_NODE   = 2'd1,
      VAL_INTERP = 2'd2
   } val_sel_type;

   typedef enum logic [1:0] {
      RD_IDX    = 2'd0,
      RD_IDX_M1 = 2'd1,
      RD_SH_M1  = 2'd2
   } rd_sel_type;

   typedef struct packed {
      logic        load_req;
      logic        clear_tbl;
      logic        set_dup;
      logic        idx_clr;
      logic        idx_inc;
      logic        sh_load;
      logic        sh_dec;
      logic        rd_en;
      rd_sel_type  rd_sel;
      logic        wr_shift;
      logic        wr_new;
      logic        cap_hi;
      logic        calc;
      logic        mul;
      logic        div_start;
      logic        res_we;
      status_type  res_status;
      val_sel_type res_val;
      logic        out_load;
   } cmd_type;

   typedef struct packed {
      req_kind_type kind;
      logic         empty;
      logic         full;
      logic         dup;
      logic         at_end;
      logic         idx_zero;
      logic         ge;
      logic         eq;
      logic         sh_at_pos;
      logic         div_done;
      logic         out_free;
   } flags_type;

endpackage

[rtl/piecewise_linear_interpolator.sv]
// Piecewise linear interpolator over a sorted table of up to 64 Q16.16 nodes.
// Insert: linear scan, then entry shift through the one-port table, then the new write.
// Query: linear scan, then, between two nodes, multiply and the serial divider. Clear and
// unused codes answer directly. One request is worked at a time.
// Synchronous active-high reset empties the table and drops the duplicate flag.
module piecewise_linear_interpolator (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_type,
   input  logic signed [31:0]  req_node_x,
   input  logic signed [31:0]  req_node_y,
   input  logic signed [31:0]  req_query_x,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [2:0]          rsp_status,
   output logic signed [31:0]  rsp_value,
   output logic [6:0]          rsp_stored_nodes
);
   import plin_pkg::*;

   cmd_type   cmd;
   flags_type flg;

   plin_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .flg       (flg),
      .cmd       (cmd)
   );

   plin_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .flg              (flg),
      .req_type         (req_type),
      .req_node_x       (req_node_x),
      .req_node_y       (req_node_y),
      .req_query_x      (req_query_x),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_value        (rsp_value),
      .rsp_stored_nodes (rsp_stored_nodes)
   );
endmodule

[rtl/plin_div.sv]
// Serial restoring divider, one quotient bit per cycle.
// Depends on plin_pkg; the upper half of the dividend must be below the divisor.
module plin_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [2*plin_pkg::DATA_W-1:0] dividend,
   input  logic [plin_pkg::DATA_W-1:0]   divisor,
   output logic                        done,
   output logic [plin_pkg::DATA_W-1:0]   quotient
);
   import plin_pkg::*;

   logic [DATA_W-1:0] rem_ff, acc_ff;
   logic [STEP_W-1:0] cnt_ff;
   logic              busy_ff, done_ff;
   logic [DATA_W+1:0] diff;
   logic              fits;

   assign diff = {1'b0, rem_ff, acc_ff[DATA_W-1]} - {2'b00, divisor};
   assign fits = !diff[DATA_W+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            rem_ff  <= dividend[2*DATA_W-1:DATA_W];
            acc_ff  <= dividend[DATA_W-1:0];
            cnt_ff  <= '0;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            rem_ff <= fits ? diff[DATA_W-1:0] : {rem_ff[DATA_W-2:0], acc_ff[DATA_W-1]};
            acc_ff <= {acc_ff[DATA_W-2:0], fits};
            cnt_ff <= cnt_ff + STEP_W'(1);
            if (cnt_ff == STEP_W'(DATA_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = acc_ff;
endmodule

[rtl/plin_ctrl.sv]
// Controller of the interpolator: sequences scan, shift, multiply and divide.
// Depends on plin_pkg; drives the datapath through cmd_type, reads flags_type.
module plin_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  plin_pkg::flags_type flg,
   output plin_pkg::cmd_type   cmd
);
   import plin_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_DISPATCH, S_SCAN_RD, S_SCAN_CMP, S_SCAN_END, S_SHIFT_RD, S_SHIFT_WR,
      S_WRITE_NEW, S_LO_CAP, S_MUL, S_DIV_GO, S_DIV_WAIT, S_DONE
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            case (flg.kind)
               REQ_INSERT: begin
                  cmd.idx_clr = 1'b1;
                  state_in    = S_SCAN_RD;
               end
               REQ_QUERY: begin
                  if (flg.empty) begin
                     cmd.res_we     = 1'b1;
                     cmd.res_status = ST_EMPTY;
                     state_in       = S_DONE;
                  end else if (flg.dup) begin
                     cmd.res_we     = 1'b1;
                     cmd.res_status = ST_INVALID;
                     state_in       = S_DONE;
                  end else begin
                     cmd.idx_clr = 1'b1;
                     state_in    = S_SCAN_RD;
                  end
               end
               REQ_CLEAR: begin
                  cmd.clear_tbl  = 1'b1;
                  cmd.res_we     = 1'b1;
                  cmd.res_status = ST_OK;
                  state_in       = S_DONE;
               end
               default: begin
                  cmd.res_we     = 1'b1;
                  cmd.res_status = ST_OK;
                  state_in       = S_DONE;
               end
            endcase
         end
         S_SCAN_RD: begin
            if (flg.at_end) begin
               state_in = S_SCAN_END;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_IDX;
               state_in   = S_SCAN_CMP;
            end
         end
         S_SCAN_CMP: begin
            if (flg.ge) begin
               state_in = S_SCAN_END;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = S_SCAN_RD;
            end
         end
         S_SCAN_END: begin
            cmd.res_we = 1'b1;
            state_in   = S_DONE;
            if (flg.kind == REQ_INSERT) begin
               if (flg.eq) begin
                  cmd.set_dup    = 1'b1;
                  cmd.res_status = ST_INVALID;
               end else if (flg.full) begin
                  cmd.res_status = ST_FULL;
               end else begin
                  cmd.res_we  = 1'b0;
                  cmd.sh_load = 1'b1;
                  state_in    = S_SHIFT_RD;
               end
            end else begin
               if (flg.eq) begin
                  cmd.res_status = ST_OK;
                  cmd.res_val    = VAL_NODE;
               end else if (flg.at_end || flg.idx_zero) begin
                  cmd.res_status = ST_RANGE;
               end else begin
                  // The scanned entry is the upper node; fetch the one below it.
                  cmd.res_we = 1'b0;
                  cmd.cap_hi = 1'b1;
                  cmd.rd_en  = 1'b1;
                  cmd.rd_sel = RD_IDX_M1;
                  state_in   = S_LO_CAP;
               end
            end
         end
         S_SHIFT_RD: begin
            if (flg.sh_at_pos) begin
               state_in = S_WRITE_NEW;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_SH_M1;
               state_in   = S_SHIFT_WR;
            end
         end
         S_SHIFT_WR: begin
            cmd.wr_shift = 1'b1;
            cmd.sh_dec   = 1'b1;
            state_in     = S_SHIFT_RD;
         end
         S_WRITE_NEW: begin
            cmd.wr_new     = 1'b1;
            cmd.res_we     = 1'b1;
            cmd.res_status = ST_OK;
            state_in       = S_DONE;
         end
         S_LO_CAP: begin
            cmd.calc = 1'b1;
            state_in = S_MUL;
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_DIV_GO;
         end
         S_DIV_GO: begin
            cmd.div_start = 1'b1;
            state_in      = S_DIV_WAIT;
         end
         S_DIV_WAIT: begin
            if (flg.div_done) begin
               cmd.res_we     = 1'b1;
               cmd.res_status = ST_OK;
               cmd.res_val    = VAL_INTERP;
               state_in       = S_DONE;
            end
         end
         S_DONE: begin
            if (flg.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end
endmodule

[rtl/plin_dpath.sv]
// Datapath of the interpolator: node tables, scan pointers, arithmetic, result.
// Depends on plin_pkg and plin_div; controlled by plin_ctrl.
module plin_dpath (
   input  logic                       clock,
   input  logic                       reset,
   input  plin_pkg::cmd_type          cmd,
   output plin_pkg::flags_type        flg,
   input  logic [1:0]                 req_type,
   input  logic signed [31:0]         req_node_x,
   input  logic signed [31:0]         req_node_y,
   input  logic signed [31:0]         req_query_x,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [2:0]                 rsp_status,
   output logic signed [31:0]         rsp_value,
   output logic [6:0]                 rsp_stored_nodes
);
   import plin_pkg::*;

   logic signed [DATA_W-1:0] xmem [MAX_NODES];
   logic signed [DATA_W-1:0] ymem [MAX_NODES];

   req_kind_type             kind_ff;
   logic signed [DATA_W-1:0] nx_ff, ny_ff, qx_ff, key;
   logic [CNT_W-1:0]         total_ff, idx_ff, sh_ff, idx_m1, sh_m1;
   logic                     dup_ff;
   logic signed [DATA_W-1:0] x_rd_ff, y_rd_ff, x1_ff, y1_ff, y0_ff;
   logic [IDX_W-1:0]         rd_addr, wr_addr;
   logic                     wr_en;
   logic signed [DATA_W-1:0] wr_x, wr_y;
   logic signed [DATA_W:0]   dy, dq, dx;
   logic [DATA_W:0]          dy_abs;
   logic                     neg_ff;
   logic [DATA_W-1:0]        mag_ff, dq_ff, dx_ff, quot;
   logic [2*DATA_W-1:0]      prod_ff;
   logic                     div_done;
   logic signed [DATA_W-1:0] interp;
   status_type               res_status_ff;
   logic signed [DATA_W-1:0] res_value_ff, res_value_in;
   logic                     rsp_valid_ff;
   logic [2:0]               rsp_status_ff;
   logic signed [DATA_W-1:0] rsp_value_ff;
   logic [6:0]               rsp_nodes_ff;

   assign key    = (kind_ff == REQ_INSERT) ? nx_ff : qx_ff;
   assign idx_m1 = idx_ff - CNT_W'(1);
   assign sh_m1  = sh_ff - CNT_W'(1);

   always_comb begin
      case (cmd.rd_sel)
         RD_IDX_M1: rd_addr = idx_m1[IDX_W-1:0];
         RD_SH_M1:  rd_addr = sh_m1[IDX_W-1:0];
         default:   rd_addr = idx_ff[IDX_W-1:0];
      endcase
   end

   assign wr_en   = cmd.wr_shift || cmd.wr_new;
   assign wr_addr = cmd.wr_shift ? sh_ff[IDX_W-1:0] : idx_ff[IDX_W-1:0];
   assign wr_x    = cmd.wr_shift ? x_rd_ff : nx_ff;
   assign wr_y    = cmd.wr_shift ? y_rd_ff : ny_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         xmem[wr_addr] <= wr_x;
         ymem[wr_addr] <= wr_y;
      end
      if (cmd.rd_en) begin
         x_rd_ff <= xmem[rd_addr];
         y_rd_ff <= ymem[rd_addr];
      end
   end

   // Control state: table fill, duplicate flag, pointers, output valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff      <= REQ_INSERT;
         total_ff     <= '0;
         dup_ff       <= 1'b0;
         idx_ff       <= '0;
         sh_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.load_req) begin
            kind_ff <= req_kind_type'(req_type);
         end
         if (cmd.clear_tbl) begin
            total_ff <= '0;
            dup_ff   <= 1'b0;
         end else begin
            if (cmd.set_dup) begin
               dup_ff <= 1'b1;
            end
            if (cmd.wr_new) begin
               total_ff <= total_ff + CNT_W'(1);
            end
         end
         if (cmd.idx_clr) begin
            idx_ff <= '0;
         end else if (cmd.idx_inc) begin
            idx_ff <= idx_ff + CNT_W'(1);
         end
         if (cmd.sh_load) begin
            sh_ff <= total_ff;
         end else if (cmd.sh_dec) begin
            sh_ff <= sh_m1;
         end
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign dy     = {y1_ff[DATA_W-1], y1_ff} - {y_rd_ff[DATA_W-1], y_rd_ff};
   assign dq     = {qx_ff[DATA_W-1], qx_ff} - {x_rd_ff[DATA_W-1], x_rd_ff};
   assign dx     = {x1_ff[DATA_W-1], x1_ff} - {x_rd_ff[DATA_W-1], x_rd_ff};
   assign dy_abs = dy[DATA_W] ? (DATA_W + 1)'(-dy) : dy;

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         nx_ff <= req_node_x;
         ny_ff <= req_node_y;
         qx_ff <= req_query_x;
      end
      if (cmd.cap_hi) begin
         x1_ff <= x_rd_ff;
         y1_ff <= y_rd_ff;
      end
      if (cmd.calc) begin
         y0_ff  <= y_rd_ff;
         neg_ff <= dy[DATA_W];
         mag_ff <= dy_abs[DATA_W-1:0];
         dq_ff  <= dq[DATA_W-1:0];
         dx_ff  <= dx[DATA_W-1:0];
      end
      if (cmd.mul) begin
         prod_ff <= (2*DATA_W)'(mag_ff) * (2*DATA_W)'(dq_ff);
      end
   end

   plin_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (prod_ff),
      .divisor  (dx_ff),
      .done     (div_done),
      .quotient (quot)
   );

   assign interp = neg_ff ? (y0_ff - $signed(quot)) : (y0_ff + $signed(quot));

   always_comb begin
      case (cmd.res_val)
         VAL_NODE:   res_value_in = y_rd_ff;
         VAL_INTERP: res_value_in = interp;
         default:    res_value_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.res_we) begin
         res_status_ff <= cmd.res_status;
         res_value_ff  <= res_value_in;
      end
      if (cmd.out_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_value_ff  <= res_value_ff;
         rsp_nodes_ff  <= 7'(total_ff);
      end
   end

   always_comb begin
      flg           = '0;
      flg.kind      = kind_ff;
      flg.empty     = (total_ff == '0);
      flg.full      = (total_ff == CNT_W'(MAX_NODES));
      flg.dup       = dup_ff;
      flg.at_end    = (idx_ff == total_ff);
      flg.idx_zero  = (idx_ff == '0);
      flg.ge        = (x_rd_ff >= key);
      flg.eq        = (idx_ff != total_ff) && (x_rd_ff == key);
      flg.sh_at_pos = (sh_ff == idx_ff);
      flg.div_done  = div_done;
      flg.out_free  = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_value        = rsp_value_ff;
   assign rsp_stored_nodes = rsp_nodes_ff;
endmodule

[rtl/plin_chk.sv]
// Port-level checker of the interpolator, bound to the top level.
// Depends on plin_pkg and assert_macros.svh.
`include "assert_macros.svh"
module plin_chk (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [2:0]         rsp_status,
   input logic signed [31:0] rsp_value,
   input logic [6:0]         rsp_stored_nodes
);
   import plin_pkg::*;

   // A failed request never carries a nonzero value.
   `ASSERT_IMPLIES(a_err_zero, clock, reset, rsp_valid && (rsp_status != ST_OK), rsp_value == '0)
   // A full refusal reports a table holding every node.
   `ASSERT_IMPLIES(a_full_cnt, clock, reset, rsp_valid && (rsp_status == ST_FULL), rsp_stored_nodes == 7'(MAX_NODES))
   `ASSERT_NEXT(a_hold_valid, clock, reset, rsp_valid && rsp_stall, rsp_valid)
   `ASSERT_NEXT(a_hold_data, clock, reset, rsp_valid && rsp_stall, $stable(rsp_value) && $stable(rsp_status))
endmodule

bind piecewise_linear_interpolator plin_chk u_chk (.*);
